### hw/rtl/phf_pkg.sv
`timescale 1ns / 1ps

package phf_pkg;

    // packet format codes
    localparam logic [3:0] FMT_LONG_RD  = 4'd0;
    localparam logic [3:0] FMT_LONG_WR  = 4'd1;
    localparam logic [3:0] FMT_MSG      = 4'd2;
    localparam logic [3:0] FMT_SHORT_RD = 4'd8;
    localparam logic [3:0] FMT_SHORT_WR = 4'd9;

    // tuser codes on the input side
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 32;

    localparam logic [31:0] BAD_FMT_WORD = 32'hFFFF_FFFF;

    // input word, last field (length) in the lowest bits
    typedef struct packed {
        logic [4:0]  pad;
        logic [31:0] data_word;
        logic [29:0] address;
        logic [3:0]  format;
        logic [4:0]  requester;
        logic [4:0]  destination;
        logic [3:0]  last_be;
        logic [3:0]  start_be;
        logic [6:0]  length;
    } t_in_word;

    // one queued output word
    typedef struct packed {
        logic [31:0] word;
        logic        is_header;
        logic        last;
    } t_out_word;

endpackage

### hw/rtl/packet_header_framer.sv
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                         tuser       tlast
// s_axis    in   length[6:0] start_be[3:0] last_be[3:0]     kind        -
//                destination[4:0] requester[4:0] format[3:0]
//                address[29:0] data_word[31:0], 5 zero bits
// m_axis    out  word[31:0]                                 is_header   last
//
// An accepted word's results are registered in a two-entry output queue and
// are held there from the following cycle until the output takes them.
// Data words and one-word headers sustain one word per cycle while the
// output is ready; a long header fills both entries and holds off the input.
// The input is ready only when the queue is empty after this cycle's pop.
// Synchronous active-low reset empties the queue and clears the word count.
// Output stalls hold the queue head; the input backs up behind it.

module packet_header_framer
    import phf_pkg::*;
#(
    parameter int LONG_MAX_WORDS  = 128,
    parameter int SHORT_MAX_WORDS = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // length, start_be, last_be, destination, requester, format, address,
    // data_word, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // kind
    input  logic                   i_s_axis_tuser,

    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // word
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // is_header
    output logic                   o_m_axis_tuser,
    output logic                   o_m_axis_tlast
);

    localparam logic [7:0] LongMax  = 8'(LONG_MAX_WORDS);
    localparam logic [2:0] ShortMax = 3'(SHORT_MAX_WORDS);

    t_in_word    w_in;
    t_out_word   r_buf [2];
    t_out_word   n_buf [2];
    t_out_word   w_res [2];
    logic [1:0]  r_cnt, n_cnt;
    logic [7:0]  r_rem, n_rem;
    logic [1:0]  w_push;
    logic [1:0]  w_base;
    logic        w_pop;
    logic        w_acc;
    logic [31:0] w_common;
    logic [7:0]  w_len8;
    logic [7:0]  w_long_cnt;
    logic [1:0]  w_sl;
    logic [2:0]  w_short_cnt;
    logic [7:0]  w_rem_dec;

    assign w_in   = t_in_word'(i_s_axis_tdata);
    assign w_pop  = (r_cnt != 2'd0) && i_m_axis_tready;
    assign w_base = r_cnt - {1'b0, w_pop};

    assign o_s_axis_tready = (w_base == 2'd0);
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // header fields common to all valid formats
    assign w_common = {w_in.format, w_in.requester, w_in.destination, 18'd0};

    assign w_len8     = {1'b0, w_in.length};
    assign w_long_cnt = (w_in.length == 7'd0) ? LongMax :
                        ((w_len8 < LongMax) ? w_len8 : LongMax);
    assign w_sl        = w_in.length[1:0];
    assign w_short_cnt = (w_sl == 2'd0) ? ShortMax :
                         (({1'b0, w_sl} < ShortMax) ? {1'b0, w_sl} : ShortMax);
    assign w_rem_dec   = r_rem - 8'd1;

    // results of the incoming word
    always_comb begin
        w_res[0] = '0;
        w_res[1] = '0;
        w_push   = 2'd0;
        n_rem    = r_rem;
        if (i_s_axis_tuser == KIND_DATA) begin
            if (r_rem != 8'd0) begin
                n_rem    = w_rem_dec;
                w_push   = 2'd1;
                w_res[0] = '{word: w_in.data_word, is_header: 1'b0,
                             last: (w_rem_dec == 8'd0)};
            end
        end else begin
            w_push = 2'd1;
            case (w_in.format) inside
                FMT_LONG_RD, FMT_LONG_WR: begin
                    n_rem    = w_long_cnt;
                    w_push   = 2'd2;
                    w_res[0] = '{word: w_common | {17'd0, w_in.last_be, w_in.start_be,
                                                   w_in.length},
                                 is_header: 1'b1, last: 1'b0};
                    w_res[1] = '{word: {w_in.address, 2'b00}, is_header: 1'b1,
                                 last: (w_long_cnt == 8'd0)};
                end
                FMT_SHORT_RD, FMT_SHORT_WR: begin
                    n_rem    = {5'd0, w_short_cnt};
                    w_res[0] = '{word: w_common | {14'd0, w_in.address[15:0], w_sl},
                                 is_header: 1'b1, last: (w_short_cnt == 3'd0)};
                end
                FMT_MSG: begin
                    n_rem    = w_len8;
                    w_res[0] = '{word: w_common | {14'd0, w_in.address[10:0],
                                                   w_in.length},
                                 is_header: 1'b1, last: (w_in.length == 7'd0)};
                end
                default: begin
                    n_rem    = 8'd0;
                    w_res[0] = '{word: BAD_FMT_WORD, is_header: 1'b1, last: 1'b1};
                end
            endcase
        end
    end

    // queue: survivors shift down, new results land behind them
    always_comb begin
        n_buf[0] = (w_base != 2'd0) ? (w_pop ? r_buf[1] : r_buf[0]) : w_res[0];
        case (w_base)
            2'd2:    n_buf[1] = r_buf[1];
            2'd1:    n_buf[1] = w_res[0];
            default: n_buf[1] = w_res[1];
        endcase
        n_cnt = w_acc ? (w_base + w_push) : w_base;
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rem <= 8'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_acc) begin
                r_rem <= n_rem;
            end
        end
    end

    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = r_buf[0].word;
    assign o_m_axis_tuser  = r_buf[0].is_header;
    assign o_m_axis_tlast  = r_buf[0].last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue overfilled");

    a_long_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_s_axis_tuser == KIND_HEADER &&
         (w_in.format == FMT_LONG_RD || w_in.format == FMT_LONG_WR))
        |=> (r_cnt == 2'd2))
        else $error("long header did not queue two words");

    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_s_axis_tuser == KIND_DATA && r_rem == 8'd0)
        |=> (r_cnt == 2'd0 && r_rem == 8'd0))
        else $error("surplus data word not dropped");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (r_cnt == 2'd0 || (r_cnt == 2'd1 && i_m_axis_tready)))
        else $error("input ready with queue occupied");

    // any format outside the known set closes at once
    a_bad_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_s_axis_tuser == KIND_HEADER &&
         !(w_in.format == FMT_LONG_RD || w_in.format == FMT_LONG_WR ||
           w_in.format == FMT_MSG || w_in.format == FMT_SHORT_RD ||
           w_in.format == FMT_SHORT_WR))
        |=> (r_rem == 8'd0 && o_m_axis_tlast))
        else $error("invalid format not closed");

endmodule

### verif/tb_packet_header_framer.sv
`timescale 1ns / 1ps

// Self-checking bench for packet_header_framer.
// Words are pushed into a pending queue up front, then a clocked driver
// presents them on the input stream. A clocked monitor predicts the framed
// output for every accepted input word and checks the output stream against
// those predictions.

module tb_packet_header_framer;
    import phf_pkg::*;

    localparam int         LONG_PKT_WORDS  = 128;
    localparam int         SHORT_PKT_WORDS = 4;
    localparam int         ITEMS_GOAL      = 1750;
    localparam int         QUIET_TAIL      = 200;   // words at the end sent with no idling
    localparam int         HOLD_CYCLES     = 300;   // one long receiver hold-off
    localparam int         HOLD_AFTER      = 600;   // input words taken before the hold-off
    localparam int         STALL_LIMIT     = 2000;  // cycles with no handshake on either side
    localparam logic [3:0] FMT_BAD_LO      = 4'd3;
    localparam logic [3:0] FMT_BAD_HI      = 4'd15;

    typedef struct packed {
        logic     kind;
        t_in_word f;
    } t_link_item;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   i_s_axis_tuser = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tuser;
    logic                   o_m_axis_tlast;

    packet_header_framer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // stimulus and scoreboard
    t_link_item pending_items[$];
    t_out_word  expected_words[$];
    logic [7:0] payload_left = 8'd0;   // predicted payload words still owed

    int total_items   = 0;
    int items_offered = 0;
    int items_in      = 0;
    int headers_in    = 0;
    int words_out     = 0;
    int full_long     = 0;
    int mismatches    = 0;
    int stall_cycles  = 0;

    // handshake flags, sampled at the rising edge, read at the falling edge
    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;

    int in_gap    = 0;
    int out_gap   = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // payload words announced by a header
    function automatic logic [7:0] words_announced(input logic [3:0] fmt,
                                                   input logic [6:0] len);
        case (fmt)
            FMT_LONG_RD, FMT_LONG_WR:
                return (len == 0 || len > LONG_PKT_WORDS) ? 8'(LONG_PKT_WORDS) : 8'(len);
            FMT_SHORT_RD, FMT_SHORT_WR:
                return (len[1:0] == 0 || len[1:0] > SHORT_PKT_WORDS) ?
                       8'(SHORT_PKT_WORDS) : 8'(len[1:0]);
            FMT_MSG:
                return 8'(len);
            default:
                return 8'd0;
        endcase
    endfunction

    function automatic void expect_word(input logic [31:0] w, input logic hdr,
                                        input logic lst);
        t_out_word e;
        e.word      = w;
        e.is_header = hdr;
        e.last      = lst;
        expected_words.push_back(e);
    endfunction

    // framing predictor: one accepted input word -> zero, one or two output words
    function automatic void frame_item(input logic kind, input t_in_word f);
        logic [13:0] route;
        logic [7:0]  cnt;
        route = {f.format, f.requester, f.destination};
        if (kind == KIND_DATA) begin
            // a payload word outside any open packet is dropped
            if (payload_left != 0) begin
                payload_left = payload_left - 8'd1;
                expect_word(f.data_word, 1'b0, payload_left == 0);
            end
            return;
        end
        // a header always restarts the count, abandoning any open packet
        cnt          = words_announced(f.format, f.length);
        payload_left = cnt;
        case (f.format)
            FMT_LONG_RD, FMT_LONG_WR: begin
                expect_word({route, 3'b000, f.last_be, f.start_be, f.length}, 1'b1, 1'b0);
                expect_word({f.address, 2'b00}, 1'b1, cnt == 0);
            end
            FMT_SHORT_RD, FMT_SHORT_WR:
                expect_word({route, f.address[15:0], f.length[1:0]}, 1'b1, cnt == 0);
            FMT_MSG:
                expect_word({route, f.address[10:0], f.length}, 1'b1, cnt == 0);
            default:
                expect_word(BAD_FMT_WORD, 1'b1, 1'b1);
        endcase
    endfunction

    // idling in bursts, with a quiet third of every 480 words and a quiet tail
    function automatic bit idling_allowed();
        return items_offered < total_items - QUIET_TAIL && (items_offered / 160) % 3 != 2;
    endfunction

    task automatic add_header(input logic [3:0] fmt, input logic [6:0] len,
                              input logic [3:0] fbe, input logic [3:0] lbe,
                              input logic [4:0] dst, input logic [4:0] req,
                              input logic [29:0] addr);
        t_link_item it;
        it.kind          = KIND_HEADER;
        it.f.pad         = '0;
        it.f.data_word   = $urandom();
        it.f.address     = addr;
        it.f.format      = fmt;
        it.f.requester   = req;
        it.f.destination = dst;
        it.f.last_be     = lbe;
        it.f.start_be    = fbe;
        it.f.length      = len;
        pending_items.push_back(it);
    endtask

    // header fields of a payload word are random; the block ignores them
    task automatic add_data(input logic [31:0] w);
        t_link_item it;
        it.kind        = KIND_DATA;
        it.f           = t_in_word'({$urandom(), $urandom(), $urandom()});
        it.f.pad       = '0;
        it.f.data_word = w;
        pending_items.push_back(it);
    endtask

    task automatic add_random_header(input logic [3:0] fmt, input logic [6:0] len);
        add_header(fmt, len, 4'($urandom()), 4'($urandom()), 5'($urandom()),
                   5'($urandom()), 30'($urandom()));
    endtask

    // input side: hold a word until taken, otherwise idle or load the next one
    always @(negedge i_clk) begin
        if (i_rst_n && (in_taken || !i_s_axis_tvalid)) begin
            if (in_gap > 0) begin
                in_gap = in_gap - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
                in_gap = $urandom_range(0, 5);
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                t_link_item it;
                it = pending_items.pop_front();
                i_s_axis_tdata  <= it.f;
                i_s_axis_tuser  <= it.kind;
                i_s_axis_tvalid <= 1'b1;
                items_offered++;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side: random back-pressure plus one long hold-off that fills the block
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!hold_done && items_in >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_m_axis_tready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap = out_gap - 1;
            i_m_axis_tready <= 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
            out_gap = $urandom_range(0, 5);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // monitor: predict on input words, check output words in order
    always @(posedge i_clk) begin
        in_taken  = i_s_axis_tvalid && o_s_axis_tready;
        out_taken = o_m_axis_tvalid && i_m_axis_tready;
        if (!i_rst_n) begin
            stall_cycles = 0;
        end else begin
            if (in_taken) begin
                frame_item(i_s_axis_tuser, t_in_word'(i_s_axis_tdata));
                items_in++;
                if (i_s_axis_tuser == KIND_HEADER) begin
                    headers_in++;
                end
            end
            if (out_taken) begin
                words_out++;
                if (expected_words.size() == 0) begin
                    $error("unexpected output word %h (is_header %b, last %b)",
                           o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                    mismatches++;
                end else begin
                    t_out_word e;
                    e = expected_words.pop_front();
                    if (o_m_axis_tdata !== e.word) begin
                        $error("word: expected %h, got %h", e.word, o_m_axis_tdata);
                        mismatches++;
                    end
                    if (o_m_axis_tuser !== e.is_header) begin
                        $error("is_header: expected %b, got %b", e.is_header, o_m_axis_tuser);
                        mismatches++;
                    end
                    if (o_m_axis_tlast !== e.last) begin
                        $error("last: expected %b, got %b", e.last, o_m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            stall_cycles = (in_taken || out_taken) ? 0 : stall_cycles + 1;
        end
    end

    // watchdog: nothing moving on either side for too long
    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int useful;
        int r;
        int n;
        int n_send;
        logic [3:0] fmt;
        logic [6:0] len;

        // directed words
        add_data(32'hDEAD_BEEF);                       // nothing open: dropped
        add_header(FMT_LONG_RD, 7'd1, 4'hF, 4'h0, 5'd31, 5'd0, 30'h3FFF_FFFF);
        add_data(32'hFFFF_FFFF);
        add_data(32'h0000_0000);                       // past the end: dropped
        add_header(FMT_LONG_WR, 7'd127, 4'h0, 4'hF, 5'd0, 5'd31, 30'h0);
        add_data(32'h0000_0000);
        add_data(32'h5555_5555);
        // short read, length field zero -> four payload words; abandons the long write
        add_header(FMT_SHORT_RD, 7'd0, 4'hA, 4'h5, 5'd21, 5'd10, 30'h3FFF_FFFF);
        repeat (4) add_data($urandom());
        // upper length bits are ignored in short format
        add_header(FMT_SHORT_WR, 7'h7F, 4'h5, 4'hA, 5'd10, 5'd21, 30'h3FFF_0000);
        repeat (3) add_data($urandom());
        // message with no payload: header carries last
        add_header(FMT_MSG, 7'd0, 4'hF, 4'hF, 5'd31, 5'd31, 30'h3FFF_FFFF);
        add_header(FMT_MSG, 7'd2, 4'h0, 4'h0, 5'd1, 5'd2, 30'h0000_07FF);
        repeat (2) add_data($urandom());
        // an invalid format, a stray payload word, then another invalid format
        add_header(FMT_BAD_HI, 7'h7F, 4'hF, 4'hF, 5'd31, 5'd31, 30'h3FFF_FFFF);
        add_data(32'hA5A5_A5A5);
        add_header(FMT_BAD_LO, 7'd0, 4'h0, 4'h0, 5'd0, 5'd0, 30'h0);
        // long read of 128 words, cut short by the next header
        add_header(FMT_LONG_RD, 7'd0, 4'h3, 4'hC, 5'd7, 5'd24, 30'h1555_5555);
        repeat (2) add_data($urandom());
        useful = pending_items.size();

        // random packets, mostly well formed
        while (useful < ITEMS_GOAL) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                add_data($urandom());                  // stray payload word
            end else if (r < 9) begin
                do fmt = 4'($urandom()); while (words_announced(fmt, 7'd1) != 0);
                add_random_header(fmt, 7'($urandom()));
                useful++;
            end else begin
                case ($urandom_range(0, 4))
                    0: fmt = FMT_LONG_RD;
                    1: fmt = FMT_LONG_WR;
                    2: fmt = FMT_MSG;
                    3: fmt = FMT_SHORT_RD;
                    default: fmt = FMT_SHORT_WR;
                endcase
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    len = 7'd0;
                end else if (r < 70) begin
                    len = 7'($urandom_range(1, 8));
                end else begin
                    len = 7'($urandom_range(1, 127));
                end
                if (fmt == FMT_SHORT_RD || fmt == FMT_SHORT_WR) begin
                    len = {7'($urandom()) & 7'h7C} | (len & 7'h03);
                end
                add_random_header(fmt, len);
                n = words_announced(fmt, len);
                if (n == LONG_PKT_WORDS) begin
                    full_long++;
                end
                n_send = n;
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    n_send = $urandom_range(0, n);     // truncated packet
                end else if (r == 1) begin
                    n_send = n + $urandom_range(1, 3); // overrun, extra words dropped
                end
                repeat (n_send) add_data($urandom());
                useful += 1 + ((n_send < n) ? n_send : n);
            end
        end
        total_items = pending_items.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Framed %0d input words (%0d headers, %0d full 128-word long packets) into %0d",
                 items_in, headers_in, full_long, words_out);
        $display("output words, with bursty idling on both sides and one %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
